>>> rtl/fcm_pkg.sv
// Shared types and constants for the four-channel motor command framer.
package fcm_pkg;

    localparam int unsigned SpeedW    = 16;
    localparam int unsigned NowW      = 32;
    localparam int unsigned CfgAddrW  = 3;
    localparam int unsigned CfgDataW  = 16;
    localparam int unsigned IdxW      = 5;
    localparam int unsigned InDataW   = 104;

    typedef enum logic [CfgAddrW-1:0] {
        REG_FRAME_MODE   = 3'd0,
        REG_GUARD_ENABLE = 3'd1,
        REG_GUARD_TIMEOUT = 3'd2,
        REG_START_BYTE   = 3'd3,
        REG_END_BYTE     = 3'd4,
        REG_STOP_SPEED   = 3'd5
    } cfg_reg_t;

    localparam logic [IdxW-1:0] ASCII_LAST_IDX = 5'd21;
    localparam logic [IdxW-1:0] BIN_LAST_IDX   = 5'd9;
    localparam logic [IdxW-1:0] ASCII_CR_IDX   = 5'd20;
    localparam logic [2:0]      ASCII_LAST_POS = 3'd4;

    localparam logic [7:0] ASCII_CR   = 8'h0D;
    localparam logic [7:0] ASCII_LF   = 8'h0A;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_ONE  = 8'h31;
    localparam logic [7:0] ASCII_F    = 8'h46;
    localparam logic [7:0] ASCII_R    = 8'h52;

    localparam logic signed [SpeedW-1:0] AsciiMax = 16'sd100;
    localparam logic signed [SpeedW-1:0] AsciiMin = -16'sd100;
    localparam logic signed [SpeedW-1:0] BinMin   = -16'sd32767;
    localparam logic signed [SpeedW-1:0] SpeedMin = 16'sh8000;

    localparam logic [SpeedW-1:0] ASCII_STOP_WORD = 16'h1000;
    localparam logic [7:0]        DivTenMul       = 8'd205;
    localparam logic [15:0]       TIMEOUT_RESET   = 16'd50;

    typedef struct packed {
        logic                   frame_mode;
        logic                   guard_enable;
        logic [15:0]            guard_timeout_ms;
        logic [7:0]             start_byte;
        logic [7:0]             end_byte;
        logic [SpeedW-1:0]      stop_speed;
    } cfg_t;

    // In ASCII mode a word holds {3'b0, neg, hundreds, tens, ones}.
    typedef struct packed {
        logic                   binary;
        logic                   guard_on;
        logic [3:0][SpeedW-1:0] word;
    } frame_t;

endpackage

>>> rtl/fcm_front.sv
// Front end: accepts command words, runs the kill-switch guard and prepares frame contents.
module fcm_front import fcm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [InDataW-1:0] s_tdata,
    input  logic               q_full,
    output logic               q_push,
    output frame_t             q_data
);

    logic [NowW-1:0] last_ok_time_reg;
    logic [NowW-1:0] last_ok_time_next;
    logic [NowW-1:0] now_ms;
    logic [NowW-1:0] elapsed;
    logic            pin_high;
    logic            stopping;
    logic            accept;

    logic signed [SpeedW-1:0] spd       [4];
    logic signed [SpeedW-1:0] asc_clamp [4];
    logic        [6:0]        mag       [4];
    logic        [14:0]       prod      [4];
    logic        [3:0]        quot      [4];
    logic        [6:0]        quot_x10  [4];
    logic        [3:0]        ones      [4];
    logic        [3:0]        tens      [4];
    logic                     hund      [4];
    logic        [SpeedW-1:0] asc_word  [4];
    logic        [SpeedW-1:0] bin_word  [4];

    assign now_ms   = s_tdata[96:65];
    assign pin_high = s_tdata[64];
    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign q_push   = accept;

    assign elapsed  = now_ms - last_ok_time_reg;
    assign stopping = cfg.guard_enable && !pin_high &&
                      (elapsed > {16'd0, cfg.guard_timeout_ms});

    for (genvar ch = 0; ch < 4; ch++) begin : g_chan
        assign spd[ch]       = s_tdata[ch*SpeedW +: SpeedW];
        assign asc_clamp[ch] = (spd[ch] < AsciiMin) ? AsciiMin :
                               (spd[ch] > AsciiMax) ? AsciiMax : spd[ch];
        assign mag[ch]       = asc_clamp[ch][SpeedW-1] ? 7'(-asc_clamp[ch])
                                                       : 7'(asc_clamp[ch]);
        assign prod[ch]      = {8'd0, mag[ch]} * {7'd0, DivTenMul};
        assign quot[ch]      = prod[ch][14:11];
        assign quot_x10[ch]  = {quot[ch], 3'b000} + {2'b00, quot[ch], 1'b0};
        assign ones[ch]      = 4'(mag[ch] - quot_x10[ch]);
        assign hund[ch]      = (quot[ch] == 4'd10);
        assign tens[ch]      = hund[ch] ? 4'd0 : quot[ch];
        assign asc_word[ch]  = {3'b000, asc_clamp[ch][SpeedW-1], 3'b000, hund[ch],
                                tens[ch], ones[ch]};
        assign bin_word[ch]  = (spd[ch] == SpeedMin) ? BinMin : spd[ch];

        assign q_data.word[ch] = stopping ?
                                 (cfg.frame_mode ? cfg.stop_speed : ASCII_STOP_WORD) :
                                 (cfg.frame_mode ? bin_word[ch] : asc_word[ch]);
    end

    assign q_data.binary   = cfg.frame_mode;
    assign q_data.guard_on = !stopping;

    always_comb begin
        last_ok_time_next = last_ok_time_reg;
        if (accept && cfg.guard_enable && pin_high) begin
            last_ok_time_next = now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_ok_time_reg <= '0;
        end else begin
            last_ok_time_reg <= last_ok_time_next;
        end
    end

endmodule

>>> rtl/fcm_queue.sv
// Two-entry frame queue between the front end and the byte serializer.
module fcm_queue import fcm_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  frame_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output frame_t pop_data
);

    frame_t     entry_reg [2];
    frame_t     entry_next [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        entry_next[0] = entry_reg[0];
        entry_next[1] = entry_reg[1];
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        count_next    = count_reg;
        if (push) begin
            entry_next[wr_ptr_reg] = push_data;
            wr_ptr_next            = !wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg[0] <= entry_next[0];
        entry_reg[1] <= entry_next[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/fcm_back.sv
// Back end: walks through a prepared frame and sends it out one byte per word.
module fcm_back import fcm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       q_not_empty,
    input  frame_t     q_data,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic       m_tuser
);

    frame_t            cur_reg;
    frame_t            cur_next;
    logic              cur_valid_reg;
    logic              cur_valid_next;
    logic [IdxW-1:0]   idx_reg;
    logic [IdxW-1:0]   idx_next;
    logic [1:0]        ch_reg;
    logic [1:0]        ch_next;
    logic [2:0]        pos_reg;
    logic [2:0]        pos_next;
    logic              m_tvalid_reg;
    logic              m_tvalid_next;
    logic [7:0]        m_tdata_reg;
    logic [7:0]        m_tdata_next;
    logic              m_tlast_reg;
    logic              m_tlast_next;
    logic              m_tuser_reg;
    logic              m_tuser_next;

    logic              advance;
    logic              last_byte;
    logic              load;
    logic [IdxW-1:0]   bin_k;
    logic [SpeedW-1:0] bin_sel;
    logic [SpeedW-1:0] asc_sel;
    logic [7:0]        byte_val;

    assign advance   = cur_valid_reg && (!m_tvalid_reg || m_tready);
    assign last_byte = cur_reg.binary ? (idx_reg == BIN_LAST_IDX)
                                      : (idx_reg == ASCII_LAST_IDX);
    assign load      = !cur_valid_reg || (advance && last_byte);
    assign q_pop     = load && q_not_empty;

    assign bin_k   = idx_reg - 5'd1;
    assign bin_sel = cur_reg.word[bin_k[2:1]];
    assign asc_sel = cur_reg.word[ch_reg];

    always_comb begin
        byte_val = ASCII_ZERO;
        if (cur_reg.binary) begin
            if (idx_reg == 5'd0) begin
                byte_val = cfg.start_byte;
            end else if (idx_reg == BIN_LAST_IDX) begin
                byte_val = cfg.end_byte;
            end else begin
                byte_val = bin_k[0] ? bin_sel[15:8] : bin_sel[7:0];
            end
        end else if (idx_reg == ASCII_CR_IDX) begin
            byte_val = ASCII_CR;
        end else if (idx_reg == ASCII_LAST_IDX) begin
            byte_val = ASCII_LF;
        end else begin
            case (pos_reg)
                3'd0:    byte_val = ASCII_ONE + {6'd0, ch_reg};
                3'd1:    byte_val = asc_sel[12] ? ASCII_R : ASCII_F;
                3'd2:    byte_val = ASCII_ZERO | {4'd0, asc_sel[11:8]};
                3'd3:    byte_val = ASCII_ZERO | {4'd0, asc_sel[7:4]};
                default: byte_val = ASCII_ZERO | {4'd0, asc_sel[3:0]};
            endcase
        end
    end

    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        ch_next        = ch_reg;
        pos_next       = pos_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;
        m_tuser_next   = m_tuser_reg;

        if (advance) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = byte_val;
            m_tlast_next  = last_byte;
            m_tuser_next  = cur_reg.guard_on;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (load) begin
            cur_next       = q_data;
            cur_valid_next = q_not_empty;
            idx_next       = '0;
            ch_next        = '0;
            pos_next       = '0;
        end else if (advance) begin
            idx_next = idx_reg + 5'd1;
            if (pos_reg == ASCII_LAST_POS) begin
                pos_next = '0;
                ch_next  = ch_reg + 2'd1;
            end else begin
                pos_next = pos_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg     <= cur_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            ch_reg        <= '0;
            pos_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            ch_reg        <= ch_next;
            pos_reg       <= pos_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> rtl/four_channel_motor_command_framer.sv
// Top level of the four-channel motor command framer with its configuration registers.
//
// Each word on the slave stream carries four signed speeds, the kill-switch pin
// level and a millisecond timestamp, and produces one serial command frame on the
// master stream, one byte per word: 22 bytes in ASCII mode, 10 bytes in binary mode.
// m_tlast marks the final byte of a frame and m_tuser carries the guard flag, which
// is low on every byte of a stop frame.
// When the framer is idle, a command word is registered in the queue, then in the
// serializer's frame register, and its first byte then in the m_tdata output register.
// Bytes then leave at one per cycle while m_tready is high; this rate is set by the
// byte serializer, which emits one byte from its output register each cycle.
// A two-frame queue separates the guard logic from the serializer, so s_tready
// stays high while the serializer still drains earlier frames. When m_tready is
// held low the output byte holds, the queue fills and s_tready drops.
// The user must write configuration via cfg_we, cfg_index, cfg_wdata only while idle;
// the block does not enforce this. Reset clears the queue and output, zeroes the guard
// time base and returns the registers to defaults (timeout 50 ms, all others zero).
module four_channel_motor_command_framer import fcm_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CfgAddrW-1:0] cfg_index,
    input  logic [CfgDataW-1:0] cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // speed_a [15:0], speed_b [31:16], speed_c [47:32], speed_d [63:48],
    // pin_high [64], now_ms [96:65], zero fill [103:97]
    input  logic [InDataW-1:0]  s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // out_byte [7:0]
    output logic [7:0]          m_tdata,
    output logic                m_tlast,
    // guard_on [0]
    output logic                m_tuser
);

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    frame_t push_data;
    frame_t pop_data;
    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_not_empty;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_FRAME_MODE:    cfg_next.frame_mode       = cfg_wdata[0];
                REG_GUARD_ENABLE:  cfg_next.guard_enable     = cfg_wdata[0];
                REG_GUARD_TIMEOUT: cfg_next.guard_timeout_ms = cfg_wdata;
                REG_START_BYTE:    cfg_next.start_byte       = cfg_wdata[7:0];
                REG_END_BYTE:      cfg_next.end_byte         = cfg_wdata[7:0];
                REG_STOP_SPEED:    cfg_next.stop_speed       = cfg_wdata;
                default:           cfg_next                  = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_mode       <= 1'b0;
            cfg_reg.guard_enable     <= 1'b0;
            cfg_reg.guard_timeout_ms <= TIMEOUT_RESET;
            cfg_reg.start_byte       <= '0;
            cfg_reg.end_byte         <= '0;
            cfg_reg.stop_speed       <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    fcm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    fcm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (pop_data)
    );

    fcm_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_data      (pop_data),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule
